@@ hdl/box_to_box_distance_core_assert.svh @@
// Assertion macros for the checker file of the box distance core.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BOX_TO_BOX_DISTANCE_CORE_ASSERT_SVH
`define BOX_TO_BOX_DISTANCE_CORE_ASSERT_SVH

// Same-cycle implication.
`define BTB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define BTB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/btb_pkg.sv @@
package btb_pkg;

    localparam int SUM_W      = 38;   // shared unit width
    localparam int COORD_IN_W = 16;   // width of one coordinate field
    localparam int GAP_W      = 16;
    localparam int PROD_W     = 2 * GAP_W;
    localparam int SQ_W       = 37;
    localparam int DIST_W     = 19;
    localparam int ROOT_STEPS = 19;   // one result bit per step
    localparam int STEP_W     = 5;

    localparam logic [SQ_W-1:0] SUM_SAT = '1;

    typedef enum logic
    {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed
    {
        logic carry;   // bit above the word: borrow on subtract
        logic neg;     // top bit of the word
        logic zero;
    } alu_flags_t;

endpackage

@@ hdl/btb_alu.sv @@
module btb_alu
    import btb_pkg::*;
(
    input  alu_op_t          op,
    input  logic [SUM_W-1:0] a,
    input  logic [SUM_W-1:0] b,
    output logic [SUM_W-1:0] result,
    output alu_flags_t       flags
);

    logic [SUM_W:0] wide;

    always_comb
    begin
        unique case (op)
            ALU_ADD: wide = {1'b0, a} + {1'b0, b};
            ALU_SUB: wide = {1'b0, a} - {1'b0, b};
            default: wide = {1'b0, a} + {1'b0, b};
        endcase
    end

    assign result      = wide[SUM_W-1:0];
    assign flags.carry = wide[SUM_W];
    assign flags.neg   = wide[SUM_W-1];
    assign flags.zero  = (wide[SUM_W-1:0] == '0);

endmodule

@@ hdl/btb_mul.sv @@
module btb_mul
    import btb_pkg::*;
(
    input  logic              clk,
    input  logic [GAP_W-1:0]  gap,
    output logic [PROD_W-1:0] product
);

    logic [PROD_W-1:0] product_reg;

    // Square the gap, registered.
    always_ff @(posedge clk)
    begin
        product_reg <= PROD_W'(gap) * PROD_W'(gap);
    end

    assign product = product_reg;

endmodule

@@ hdl/box_to_box_distance_core.sv @@
// A dimension runs from its transfer through GAP_HI, MUL and ACC back to IDLE, and through
//   GAP_LO as well when the first compare finds no gap; a final one adds 19 square root
//   steps and one output load, and waits further while the previous result is held by the
//   receiver. s_axis_tready is high only in IDLE, so a new dimension waits for the last.
// The single 38-bit add/subtract unit serves the gap compares, accumulation and root steps.
// Reset (rst_n low, asynchronous) clears the running sum, dimension count and output valid.
module box_to_box_distance_core
    import btb_pkg::*;
#(
    parameter int MAX_DIM     = 8,
    parameter int COORD_WIDTH = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // [15:0] first_low, [31:16] first_high, [47:32] second_low, [63:48] second_high
    input  logic [4*COORD_IN_W-1:0] s_axis_tdata,
    input  logic                    s_axis_tlast,   // final_dim

    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // [18:0] distance, [55:19] squared_distance
    output logic [DIST_W+SQ_W-1:0]  m_axis_tdata
);

    // Coordinates above the field width read as unsigned field values.
    localparam int  CW_EFF       = (COORD_WIDTH > COORD_IN_W) ? COORD_IN_W : COORD_WIDTH;
    localparam bit  SIGNED_COORD = (COORD_WIDTH <= COORD_IN_W);
    localparam logic [STEP_W-1:0] ROOT_TOP = STEP_W'(ROOT_STEPS - 1);
    localparam logic [STEP_W-1:0] DIMS_MAX = '1;
    localparam logic [STEP_W-1:0] DIM_LIMIT = STEP_W'(MAX_DIM);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_GAP_HI,
        ST_GAP_LO,
        ST_MUL,
        ST_ACC,
        ST_ROOT,
        ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [4*COORD_IN_W-1:0] in_data_reg, in_data_next;
    logic                    last_reg, last_next;
    logic [GAP_W-1:0]        gap_reg, gap_next;
    logic [SQ_W-1:0]         gap_sum_reg, gap_sum_next;
    logic [STEP_W-1:0]       dims_seen_reg, dims_seen_next;
    logic [SQ_W-1:0]         x_reg, x_next;
    logic [SUM_W-1:0]        root_reg, root_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic                    out_valid_reg, out_valid_next;
    logic [DIST_W-1:0]       dist_out_reg, dist_out_next;
    logic [SQ_W-1:0]         sq_out_reg, sq_out_next;

    alu_op_t                 alu_op;
    logic [SUM_W-1:0]        alu_a;
    logic [SUM_W-1:0]        alu_b;
    logic [SUM_W-1:0]        alu_res;
    alu_flags_t              alu_flags;
    logic [PROD_W-1:0]       product;
    logic [SUM_W-1:0]        root_bit;
    logic                    gap_pos;
    logic                    sum_sat;
    logic                    out_free;

    // Take the low CW_EFF bits of a field and extend them to the unit width.
    function automatic logic [SUM_W-1:0] coord_ext(input logic [COORD_IN_W-1:0] raw);
        logic [SUM_W-1:0] v;
        v = '0;
        for (int i = 0; i < SUM_W; i++)
        begin
            if (i < CW_EFF)
                v[i] = raw[i];
            else if (SIGNED_COORD)
                v[i] = raw[CW_EFF-1];
        end
        return v;
    endfunction

    btb_alu u_alu
    (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_res),
        .flags  (alu_flags)
    );

    btb_mul u_mul
    (
        .clk     (clk),
        .gap     (gap_reg),
        .product (product)
    );

    // Square root test bit: 4^step.
    assign root_bit = {{(SUM_W-1){1'b0}}, 1'b1} << {step_reg, 1'b0};
    assign gap_pos  = !alu_flags.neg && !alu_flags.zero;
    assign sum_sat  = (dims_seen_reg >= DIM_LIMIT) || alu_res[SQ_W];
    assign out_free = !out_valid_reg || m_axis_tready;

    // Operand select for the shared unit.
    always_comb
    begin
        alu_op = ALU_ADD;
        alu_a  = {{(SUM_W-SQ_W){1'b0}}, gap_sum_reg};
        alu_b  = {{(SUM_W-PROD_W){1'b0}}, product};
        unique case (state_reg)
            ST_GAP_HI:
            begin
                // second box wholly above the first
                alu_op = ALU_SUB;
                alu_a  = coord_ext(in_data_reg[3*COORD_IN_W-1:2*COORD_IN_W]);
                alu_b  = coord_ext(in_data_reg[2*COORD_IN_W-1:COORD_IN_W]);
            end
            ST_GAP_LO:
            begin
                // first box wholly above the second
                alu_op = ALU_SUB;
                alu_a  = coord_ext(in_data_reg[COORD_IN_W-1:0]);
                alu_b  = coord_ext(in_data_reg[4*COORD_IN_W-1:3*COORD_IN_W]);
            end
            ST_ROOT:
            begin
                alu_op = ALU_SUB;
                alu_a  = {{(SUM_W-SQ_W){1'b0}}, x_reg};
                alu_b  = root_reg | root_bit;
            end
            default:
            begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        in_data_next   = in_data_reg;
        last_next      = last_reg;
        gap_next       = gap_reg;
        gap_sum_next   = gap_sum_reg;
        dims_seen_next = dims_seen_reg;
        x_next         = x_reg;
        root_next      = root_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        dist_out_next  = dist_out_reg;
        sq_out_next    = sq_out_reg;

        // Drop the result once its transfer completes.
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    in_data_next = s_axis_tdata;
                    last_next    = s_axis_tlast;
                    state_next   = ST_GAP_HI;
                end
            end
            ST_GAP_HI:
            begin
                if (gap_pos)
                begin
                    gap_next   = alu_res[GAP_W-1:0];
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_GAP_LO;
                end
            end
            ST_GAP_LO:
            begin
                gap_next   = gap_pos ? alu_res[GAP_W-1:0] : '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                // wait for the registered square
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                gap_sum_next   = sum_sat ? SUM_SAT : alu_res[SQ_W-1:0];
                dims_seen_next = (dims_seen_reg == DIMS_MAX) ? DIMS_MAX
                                                             : dims_seen_reg + 1'b1;
                if (last_reg)
                begin
                    x_next     = gap_sum_next;
                    root_next  = '0;
                    step_next  = ROOT_TOP;
                    state_next = ST_ROOT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ROOT:
            begin
                // one bit of the root per step
                if (!alu_flags.carry)
                begin
                    x_next    = alu_res[SQ_W-1:0];
                    root_next = (root_reg >> 1) | root_bit;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                if (step_reg == '0)
                    state_next = ST_DONE;
                else
                    step_next = step_reg - 1'b1;
            end
            ST_DONE:
            begin
                // hold here until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    dist_out_next  = root_reg[DIST_W-1:0];
                    sq_out_next    = gap_sum_reg;
                    gap_sum_next   = '0;
                    dims_seen_next = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_data_reg   <= '0;
            last_reg      <= 1'b0;
            gap_reg       <= '0;
            gap_sum_reg   <= '0;
            dims_seen_reg <= '0;
            x_reg         <= '0;
            root_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            dist_out_reg  <= '0;
            sq_out_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            in_data_reg   <= in_data_next;
            last_reg      <= last_next;
            gap_reg       <= gap_next;
            gap_sum_reg   <= gap_sum_next;
            dims_seen_reg <= dims_seen_next;
            x_reg         <= x_next;
            root_reg      <= root_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            dist_out_reg  <= dist_out_next;
            sq_out_reg    <= sq_out_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {sq_out_reg, dist_out_reg};

endmodule

@@ hdl/btb_checker.sv @@
`include "box_to_box_distance_core_assert.svh"

module btb_checker
    import btb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic                   s_axis_tlast,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [DIST_W+SQ_W-1:0] m_axis_tdata
);

    logic [DIST_W-1:0] dist_val;
    logic [SQ_W-1:0]   sq;
    logic [39:0]       dist_sq;
    logic [39:0]       next_sq;

    assign dist_val = m_axis_tdata[DIST_W-1:0];
    assign sq       = m_axis_tdata[DIST_W+SQ_W-1:DIST_W];
    assign dist_sq  = 40'(dist_val) * 40'(dist_val);
    assign next_sq  = (40'(dist_val) + 40'd1) * (40'(dist_val) + 40'd1);

    // A dimension keeps s_axis_tready low while it runs the compare, multiply and accumulate states.
    `BTB_ASSERT_NEXT(a_busy_after_transfer, s_axis_tvalid && s_axis_tready, !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)

    // A final dimension also runs the square root, so s_axis_tready stays low past ACC.
    `BTB_ASSERT_NEXT(a_busy_after_final, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)

    // The distance is the floor of the square root of the squared distance.
    `BTB_ASSERT_IMPL(a_root_floor, m_axis_tvalid, (dist_sq <= 40'(sq)) && (next_sq > 40'(sq)))

    // A stalled result holds.
    `BTB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind box_to_box_distance_core btb_checker u_btb_checker (.*);
